// ===== rtl/bbd_pkg.sv =====
// ----------------------------------------------------------------------------
// bbd_pkg: shared types and constants for the Bayer demosaic
// Register indexes, register widths and reset values, item kinds, sequencer
// states and the color-site codes used to route averages to channels.
// ----------------------------------------------------------------------------
package bbd_pkg;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Register widths
    localparam int PATTERN_W = 2;
    localparam int WIDTH_W   = 13;
    localparam int HEIGHT_W  = 16;
    localparam int ROW_W     = 16;

    // Register reset values
    localparam logic [PATTERN_W-1:0] PATTERN_RESET = 2'd0;
    localparam logic                 ENABLE_RESET  = 1'b1;
    localparam logic [WIDTH_W-1:0]   WIDTH_RESET   = 13'd4096;
    localparam logic [HEIGHT_W-1:0]  HEIGHT_RESET  = 16'd1;

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PATTERN = 2'd0,
        CFG_ENABLE  = 2'd1,
        CFG_WIDTH   = 2'd2,
        CFG_HEIGHT  = 2'd3
    } t_cfg_reg;

    // Input item kinds
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SUM,
        ST_EMIT
    } t_state;

    // Color site of the emitted pixel, selects which average feeds which channel
    typedef enum logic [2:0] {
        SITE_COPY,
        SITE_RED,
        SITE_BLUE,
        SITE_GREEN_RROW,
        SITE_GREEN_BROW
    } t_site;

endpackage

// ===== rtl/bayer_bilinear_demosaic_unit.sv =====
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_unit: bilinear Bayer demosaic on a raster stream
// Two previous rows live in one line memory (both rows in one word, indexed
// by column), a 3x3 window slides along the stream, and each window center
// leaves as red, green and blue with missing colors averaged from in-frame
// neighbors.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: sample; tuser: func
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: red, green, blue;
//                                               tlast: frame_end
//  cfg       in   i_cfg_we (no wait)            i_cfg_addr, i_cfg_wdata
//
//  An item that emits no pixel goes through accept and line read, then
//  read-modify-write and window shift; one that emits a pixel goes on to
//  neighbor sums, then the divide-by-three multiply and the load into the
//  output register; the line memory read-modify-write and divide set the steps.
//  The next word is accepted while a finished pixel still waits at m_axis;
//  a new pixel waits in the last step until the output register is free.
//  Reset is synchronous and needs no clearing pass; the line memory is not
//  cleared.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_unit #(
    parameter int MAX_WIDTH   = 4096,
    parameter int SAMPLE_BITS = 16,
    localparam int IN_DW      = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_DW     = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [IN_DW-1:0]                s_axis_tdata,  // [SB-1:0] sample
    input  logic                            s_axis_tuser,  // [0] func
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [OUT_DW-1:0]               m_axis_tdata,  // red, green, blue
    output logic                            m_axis_tlast,  // frame_end
    // configuration
    input  logic                            i_cfg_we,
    input  logic [bbd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [bbd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int SB     = SAMPLE_BITS;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int W_W    = COL_W + 1;
    localparam int ROW_W  = bbd_pkg::ROW_W;
    localparam int SUM_W  = SB + 2;
    localparam int DIV_K  = SUM_W + 1;
    localparam int PROD_W = SUM_W + DIV_K;
    localparam logic [DIV_K-1:0] DIV3_M =
        DIV_K'(((64'd1 << DIV_K) + 64'd2) / 64'd3);

    // Configuration registers
    logic [bbd_pkg::PATTERN_W-1:0] r_cfg_pattern;
    logic                          r_cfg_enable;
    logic [bbd_pkg::WIDTH_W-1:0]   r_cfg_width;
    logic [bbd_pkg::HEIGHT_W-1:0]  r_cfg_height;

    // Sequencer and position state
    bbd_pkg::t_state r_state, n_state;
    logic [ROW_W-1:0] r_in_row, r_out_row;
    logic [COL_W-1:0] r_in_col, r_out_col;

    // Item and window
    logic [SB-1:0]   r_sample;
    logic [SB-1:0]   r_win [3][3];

    // Line memory: upper half is the row above the middle row
    logic [2*SB-1:0] mem [MAX_WIDTH];
    logic [2*SB-1:0] r_mem_rdata;
    logic            mem_rd, mem_we;

    // Neighbor sums for the two missing colors
    logic [SUM_W-1:0]  r_sum [2], n_sum [2];
    logic [2:0]        r_cnt [2], n_cnt [2];
    bbd_pkg::t_site    r_site, n_site;
    logic              r_last, n_last;
    logic              r_wrap_out, n_wrap_out;

    // Output register
    logic              r_out_valid;
    logic [3*SB-1:0]   r_out_rgb;
    logic              r_out_last;

    logic [W_W-1:0]    w;
    logic [ROW_W-1:0]  h;
    logic              emit, wrap_in, out_ready, load;
    logic [SB-1:0]     q [2];
    logic [SB-1:0]     red, grn, blu;

    // Hold configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pattern <= bbd_pkg::PATTERN_RESET;
            r_cfg_enable  <= bbd_pkg::ENABLE_RESET;
            r_cfg_width   <= bbd_pkg::WIDTH_RESET;
            r_cfg_height  <= bbd_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (bbd_pkg::t_cfg_reg'(i_cfg_addr))
                bbd_pkg::CFG_PATTERN: r_cfg_pattern <= i_cfg_wdata[bbd_pkg::PATTERN_W-1:0];
                bbd_pkg::CFG_ENABLE:  r_cfg_enable  <= i_cfg_wdata[0];
                bbd_pkg::CFG_WIDTH:   r_cfg_width   <= i_cfg_wdata[bbd_pkg::WIDTH_W-1:0];
                bbd_pkg::CFG_HEIGHT:  r_cfg_height  <= i_cfg_wdata[bbd_pkg::HEIGHT_W-1:0];
            endcase
        end
    end

    // Clamp geometry: width to 1..MAX_WIDTH, height to at least 1
    always_comb begin
        if (r_cfg_width == '0) begin
            w = W_W'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w = W_W'(MAX_WIDTH);
        end else begin
            w = W_W'(r_cfg_width);
        end
        h = (r_cfg_height == '0) ? ROW_W'(1) : r_cfg_height;
    end

    assign emit    = (r_in_row >= ROW_W'(2)) || (r_in_row == ROW_W'(1) && r_in_col != '0);
    assign wrap_in = ({1'b0, r_in_col} + W_W'(1)) >= w;
    assign out_ready = !r_out_valid || m_axis_tready;

    // Sequencer: next state and strobes
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        mem_rd        = 1'b0;
        mem_we        = 1'b0;
        load          = 1'b0;
        unique case (r_state)
            bbd_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                mem_rd        = s_axis_tvalid;
                if (s_axis_tvalid) begin
                    n_state = bbd_pkg::ST_SHIFT;
                end
            end
            bbd_pkg::ST_SHIFT: begin
                mem_we  = 1'b1;
                n_state = emit ? bbd_pkg::ST_SUM : bbd_pkg::ST_IDLE;
            end
            bbd_pkg::ST_SUM: begin
                n_state = bbd_pkg::ST_EMIT;
            end
            bbd_pkg::ST_EMIT: begin
                if (out_ready) begin
                    load    = 1'b1;
                    n_state = bbd_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Line memory: read at accept, write back the shifted pair in the next cycle
    always_ff @(posedge i_clk) begin
        if (mem_rd) begin
            r_mem_rdata <= mem[r_in_col];
        end
        if (mem_we) begin
            mem[r_in_col] <= {r_mem_rdata[SB-1:0], r_sample};
        end
    end

    // Latch the word; a flush enters as a zero sample
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_sample <= (s_axis_tuser == bbd_pkg::FUNC_FLUSH) ? '0 : s_axis_tdata[SB-1:0];
        end
    end

    // Shift the window by one column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (r_state == bbd_pkg::ST_SHIFT) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= r_mem_rdata[2*SB-1:SB];
            r_win[1][2] <= r_mem_rdata[SB-1:0];
            r_win[2][2] <= r_sample;
        end
    end

    // Advance input and output positions; frame end returns all to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else if (r_state == bbd_pkg::ST_SHIFT) begin
            if (wrap_in) begin
                r_in_col <= '0;
                r_in_row <= r_in_row + ROW_W'(1);
            end else begin
                r_in_col <= r_in_col + COL_W'(1);
            end
        end else if (load) begin
            if (r_last) begin
                r_out_row <= '0;
                r_out_col <= '0;
                r_in_row  <= '0;
                r_in_col  <= '0;
            end else if (r_wrap_out) begin
                r_out_col <= '0;
                r_out_row <= r_out_row + ROW_W'(1);
            end else begin
                r_out_col <= r_out_col + COL_W'(1);
            end
        end
    end

    // Pick neighbors by site and sum those inside the frame
    always_comb begin
        logic up, dn, lf, rt, rr, rc, ym, xm;
        logic [SUM_W-1:0] cs, ds, hs, vs;
        logic [2:0]       cc, dc, hc, vc;
        up = r_out_row != '0;
        dn = ({1'b0, r_out_row} + (ROW_W + 1)'(1)) < {1'b0, h};
        lf = r_out_col != '0;
        rt = ({1'b0, r_out_col} + W_W'(1)) < w;
        rr = r_cfg_pattern[1];
        rc = r_cfg_pattern[1] ^ r_cfg_pattern[0];
        ym = r_out_row[0];
        xm = r_out_col[0];

        cs = (up ? SUM_W'(r_win[0][1]) : '0) + (dn ? SUM_W'(r_win[2][1]) : '0)
           + (lf ? SUM_W'(r_win[1][0]) : '0) + (rt ? SUM_W'(r_win[1][2]) : '0);
        cc = 3'(up) + 3'(dn) + 3'(lf) + 3'(rt);
        ds = ((up && lf) ? SUM_W'(r_win[0][0]) : '0) + ((up && rt) ? SUM_W'(r_win[0][2]) : '0)
           + ((dn && lf) ? SUM_W'(r_win[2][0]) : '0) + ((dn && rt) ? SUM_W'(r_win[2][2]) : '0);
        dc = 3'(up && lf) + 3'(up && rt) + 3'(dn && lf) + 3'(dn && rt);
        hs = (lf ? SUM_W'(r_win[1][0]) : '0) + (rt ? SUM_W'(r_win[1][2]) : '0);
        hc = 3'(lf) + 3'(rt);
        vs = (up ? SUM_W'(r_win[0][1]) : '0) + (dn ? SUM_W'(r_win[2][1]) : '0);
        vc = 3'(up) + 3'(dn);

        n_last     = !dn && !rt;
        n_wrap_out = !rt;
        if (!r_cfg_enable) begin
            n_site   = bbd_pkg::SITE_COPY;
            n_sum[0] = '0;
            n_cnt[0] = '0;
            n_sum[1] = '0;
            n_cnt[1] = '0;
        end else if (ym == rr && xm == rc) begin
            n_site   = bbd_pkg::SITE_RED;
            n_sum[0] = cs;
            n_cnt[0] = cc;
            n_sum[1] = ds;
            n_cnt[1] = dc;
        end else if (ym != rr && xm != rc) begin
            n_site   = bbd_pkg::SITE_BLUE;
            n_sum[0] = cs;
            n_cnt[0] = cc;
            n_sum[1] = ds;
            n_cnt[1] = dc;
        end else begin
            n_site   = (ym == rr) ? bbd_pkg::SITE_GREEN_RROW : bbd_pkg::SITE_GREEN_BROW;
            n_sum[0] = hs;
            n_cnt[0] = hc;
            n_sum[1] = vs;
            n_cnt[1] = vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bbd_pkg::ST_SUM) begin
            r_sum[0]   <= n_sum[0];
            r_cnt[0]   <= n_cnt[0];
            r_sum[1]   <= n_sum[1];
            r_cnt[1]   <= n_cnt[1];
            r_site     <= n_site;
            r_last     <= n_last;
            r_wrap_out <= n_wrap_out;
        end
    end

    // Divide each sum by its count; three goes through a reciprocal multiply
    always_comb begin
        logic [PROD_W-1:0] prod;
        for (int i = 0; i < 2; i++) begin
            prod = PROD_W'(r_sum[i]) * PROD_W'(DIV3_M);
            case (r_cnt[i])
                3'd1:    q[i] = r_sum[i][SB-1:0];
                3'd2:    q[i] = r_sum[i][SB:1];
                3'd3:    q[i] = prod[DIV_K +: SB];
                3'd4:    q[i] = r_sum[i][SB+1:2];
                default: q[i] = r_win[1][1];
            endcase
        end
    end

    // Route averages and center to the three channels
    always_comb begin
        red = r_win[1][1];
        grn = r_win[1][1];
        blu = r_win[1][1];
        unique case (r_site)
            bbd_pkg::SITE_COPY: begin
            end
            bbd_pkg::SITE_RED: begin
                grn = q[0];
                blu = q[1];
            end
            bbd_pkg::SITE_BLUE: begin
                grn = q[0];
                red = q[1];
            end
            bbd_pkg::SITE_GREEN_RROW: begin
                red = q[0];
                blu = q[1];
            end
            bbd_pkg::SITE_GREEN_BROW: begin
                blu = q[0];
                red = q[1];
            end
            default: begin
            end
        endcase
    end

    // Output register: load a finished pixel, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_rgb  <= {blu, grn, red};
            r_out_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DW'(r_out_rgb);
    assign m_axis_tlast  = r_out_last;

    // Accepted word always goes to the line memory update next
    a_accept_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == bbd_pkg::ST_SHIFT))
        else $error("accepted word did not reach the shift step");

    // A position that emits nothing returns straight to idle
    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bbd_pkg::ST_SHIFT && !emit) |=> (r_state == bbd_pkg::ST_IDLE))
        else $error("non-emitting word went on to the sum step");

    // A new output word only comes from the emit step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == bbd_pkg::ST_EMIT))
        else $error("output word appeared outside the emit step");

    // The last pixel of a frame restarts the input position
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_last) |=> (r_in_row == '0 && r_in_col == '0 && r_out_col == '0))
        else $error("frame end did not clear the positions");

endmodule

// ===== tb/bbd_demosaic_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_demosaic_checker: pixel predictor and comparator for the Bayer demosaic
// Watches the input stream, the output stream and the register port. Every
// accepted input word runs through a bilinear demosaic model with its own
// line stores, window and frame counters; the pixels it emits are queued and
// compared field by field against the words that leave the block.
// ----------------------------------------------------------------------------
module bbd_demosaic_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream as seen by the block
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [15:0]                     i_in_data,    // [15:0] sample
    input  logic                            i_in_user,    // [0] func
    // output stream as seen by the block
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [47:0]                     i_out_data,   // [15:0] red, [31:16] green,
                                                          // [47:32] blue
    input  logic                            i_out_last,   // frame_end
    // register port
    input  logic                            i_cfg_we,
    input  logic [bbd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [bbd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // status toward the stimulus side
    output int                              o_pending,
    output bit                              o_at_frame_start,
    output int                              o_fail_count
);

    localparam int LINE_DEPTH = 4096;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        frame_end;
    } t_rgb_pixel;

    // Model copy of the registers
    logic [bbd_pkg::PATTERN_W-1:0] pattern_r;
    logic                          enable_r;
    logic [bbd_pkg::WIDTH_W-1:0]   width_r;
    logic [bbd_pkg::HEIGHT_W-1:0]  height_r;

    // Model copy of the line stores, window and frame position
    logic [15:0]  line_mem [0:2*LINE_DEPTH-1];
    logic [15:0]  win [0:2][0:2];
    int unsigned  in_row;
    int unsigned  in_col;
    int unsigned  out_row;
    int unsigned  out_col;

    t_rgb_pixel   pending_pixels [$];
    int           fail_count = 0;

    // Truncated mean of the in-frame neighbors, center sample when none
    function automatic logic [15:0] mean_or_center(int unsigned sum, int unsigned cnt);
        if (cnt == 0)
            return win[1][1];
        return 16'(sum / cnt);
    endfunction

    // Advance the stream by one word and queue the pixel that leaves, if any
    task automatic demosaic_step(input logic func, input logic [15:0] smp);
        int unsigned w, h;
        int unsigned cross_sum, cross_cnt, diag_sum, diag_cnt;
        int unsigned hz_sum, hz_cnt, vt_sum, vt_cnt;
        logic [15:0] s, top_v, mid_v, ctr;
        bit          emit, up, dn, lf, rt, last, red_row, red_col;
        bbd_pkg::t_site site;
        t_rgb_pixel  px;

        w = (width_r == 0) ? 1 : ((width_r > LINE_DEPTH) ? LINE_DEPTH : width_r);
        h = (height_r == 0) ? 1 : height_r;
        s = (func == bbd_pkg::FUNC_FLUSH) ? 16'd0 : smp;
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);

        // roll the two line stores at this column
        top_v = '0;
        mid_v = '0;
        if (in_col < LINE_DEPTH) begin
            top_v = line_mem[LINE_DEPTH + in_col];
            mid_v = line_mem[in_col];
            line_mem[LINE_DEPTH + in_col] = mid_v;
            line_mem[in_col] = s;
        end

        // shift the window one column left and load the new column
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top_v;
        win[1][2] = mid_v;
        win[2][2] = s;

        if (in_col + 1 >= w) begin
            in_col = 0;
            in_row = (in_row + 1) & 32'hFFFF;
        end else begin
            in_col++;
        end

        if (!emit)
            return;

        ctr  = win[1][1];
        up   = out_row > 0;
        dn   = out_row + 1 < h;
        lf   = out_col > 0;
        rt   = out_col + 1 < w;
        last = (out_row + 1 >= h) && (out_col + 1 >= w);

        cross_sum = (up ? win[0][1] : 16'd0) + (dn ? win[2][1] : 16'd0)
                  + (lf ? win[1][0] : 16'd0) + (rt ? win[1][2] : 16'd0);
        cross_cnt = int'(up) + int'(dn) + int'(lf) + int'(rt);
        diag_sum  = ((up && lf) ? win[0][0] : 16'd0) + ((up && rt) ? win[0][2] : 16'd0)
                  + ((dn && lf) ? win[2][0] : 16'd0) + ((dn && rt) ? win[2][2] : 16'd0);
        diag_cnt  = int'(up && lf) + int'(up && rt) + int'(dn && lf) + int'(dn && rt);
        hz_sum    = (lf ? win[1][0] : 16'd0) + (rt ? win[1][2] : 16'd0);
        hz_cnt    = int'(lf) + int'(rt);
        vt_sum    = (up ? win[0][1] : 16'd0) + (dn ? win[2][1] : 16'd0);
        vt_cnt    = int'(up) + int'(dn);

        // classify the site from the layout and the pixel parity
        red_row = pattern_r[1];
        red_col = pattern_r[0] ^ pattern_r[1];
        if (!enable_r)
            site = bbd_pkg::SITE_COPY;
        else if (out_row[0] == red_row && out_col[0] == red_col)
            site = bbd_pkg::SITE_RED;
        else if (out_row[0] != red_row && out_col[0] != red_col)
            site = bbd_pkg::SITE_BLUE;
        else if (out_row[0] == red_row)
            site = bbd_pkg::SITE_GREEN_RROW;
        else
            site = bbd_pkg::SITE_GREEN_BROW;

        px.red       = ctr;
        px.green     = ctr;
        px.blue      = ctr;
        px.frame_end = last;
        case (site)
            bbd_pkg::SITE_RED: begin
                px.green = mean_or_center(cross_sum, cross_cnt);
                px.blue  = mean_or_center(diag_sum, diag_cnt);
            end
            bbd_pkg::SITE_BLUE: begin
                px.green = mean_or_center(cross_sum, cross_cnt);
                px.red   = mean_or_center(diag_sum, diag_cnt);
            end
            bbd_pkg::SITE_GREEN_RROW: begin
                px.red  = mean_or_center(hz_sum, hz_cnt);
                px.blue = mean_or_center(vt_sum, vt_cnt);
            end
            bbd_pkg::SITE_GREEN_BROW: begin
                px.blue = mean_or_center(hz_sum, hz_cnt);
                px.red  = mean_or_center(vt_sum, vt_cnt);
            end
            default: ;
        endcase
        pending_pixels.push_back(px);

        // step the output position; the last pixel restarts the frame
        if (last) begin
            out_row = 0;
            out_col = 0;
            in_row  = 0;
            in_col  = 0;
        end else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row = (out_row + 1) & 32'hFFFF;
        end else begin
            out_col++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rgb_pixel want, got;

        if (!i_rst_n) begin
            pattern_r = bbd_pkg::PATTERN_RESET;
            enable_r  = bbd_pkg::ENABLE_RESET;
            width_r   = bbd_pkg::WIDTH_RESET;
            height_r  = bbd_pkg::HEIGHT_RESET;
            for (int i = 0; i < 2 * LINE_DEPTH; i++)
                line_mem[i] = '0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win[r][c] = '0;
            in_row  = 0;
            in_col  = 0;
            out_row = 0;
            out_col = 0;
            pending_pixels.delete();
        end else begin
            // track register writes
            if (i_cfg_we) begin
                case (bbd_pkg::t_cfg_reg'(i_cfg_addr))
                    bbd_pkg::CFG_PATTERN: pattern_r = i_cfg_wdata[bbd_pkg::PATTERN_W-1:0];
                    bbd_pkg::CFG_ENABLE:  enable_r  = i_cfg_wdata[0];
                    bbd_pkg::CFG_WIDTH:   width_r   = i_cfg_wdata[bbd_pkg::WIDTH_W-1:0];
                    bbd_pkg::CFG_HEIGHT:  height_r  = i_cfg_wdata[bbd_pkg::HEIGHT_W-1:0];
                    default: ;
                endcase
            end

            // compare a leaving word with the oldest predicted pixel
            if (i_out_valid && i_out_ready) begin
                got.red       = i_out_data[15:0];
                got.green     = i_out_data[31:16];
                got.blue      = i_out_data[47:32];
                got.frame_end = i_out_last;
                if (pending_pixels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("ERROR: pixel with nothing predicted: r=%h g=%h b=%h last=%b",
                                 got.red, got.green, got.blue, got.frame_end);
                end else begin
                    want = pending_pixels.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"ERROR: pixel mismatch: expected r=%h g=%h b=%h last=%b,",
                                      " got r=%h g=%h b=%h last=%b"},
                                     want.red, want.green, want.blue, want.frame_end,
                                     got.red, got.green, got.blue, got.frame_end);
                    end
                end
            end

            // predict from an accepted input word
            if (i_in_valid && i_in_ready)
                demosaic_step(i_in_user, i_in_data);
        end

        o_pending        <= pending_pixels.size();
        o_at_frame_start <= (in_row == 0) && (in_col == 0);
        o_fail_count     <= fail_count;
    end

endmodule

// ===== tb/tb_bayer_bilinear_demosaic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bayer_bilinear_demosaic_unit: stream test of the Bayer demosaic
// Starts a frame at reset settings and narrows it inside the frame, which
// fills both line stores over every column later frames touch. Then runs
// directed frames over sample extremes, early flushes, late samples, tiny and
// out-of-range geometry and the bypass mode, then random frames over all
// layouts with geometry changes inside frames, and ends with an oversized
// width. Both streams idle at random; a checker predicts every pixel.
// ----------------------------------------------------------------------------
module tb_bayer_bilinear_demosaic_unit;

    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_WORDS  = 500;
    localparam int FULL_WIDTH    = 4096;
    // widest line used after the first frame; widths raised inside a frame
    // must stay within columns already written
    localparam int PREFILL_WIDTH = 24;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [15:0]                     s_axis_tdata;   // [15:0] sample
    logic                            s_axis_tuser;   // [0] func
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [47:0]                     m_axis_tdata;   // [15:0] red, [31:16] green, [47:32] blue
    logic                            m_axis_tlast;   // frame_end
    logic                            i_cfg_we;
    logic [bbd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [bbd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata;

    int  chk_pending;
    int  chk_fail_count;
    bit  chk_at_frame_start;

    bit  no_idle = 1'b0;
    int  words_sent = 0;
    int  cur_w = FULL_WIDTH;
    int  cur_h = 1;
    int  quiet_cycles = 0;

    bayer_bilinear_demosaic_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    bbd_demosaic_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (s_axis_tvalid),
        .i_in_ready       (s_axis_tready),
        .i_in_data        (s_axis_tdata),
        .i_in_user        (s_axis_tuser),
        .i_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .i_out_data       (m_axis_tdata),
        .i_out_last       (m_axis_tlast),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_pending        (chk_pending),
        .o_at_frame_start (chk_at_frame_start),
        .o_fail_count     (chk_fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: hold off the output stream at random, mostly short stalls
    initial begin
        int hold;
        int roll;
        hold = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                m_axis_tready = 1'b0;
            end else if (no_idle) begin
                m_axis_tready = 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    m_axis_tready = 1'b1;
                end else begin
                    m_axis_tready = 1'b0;
                    hold = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 35);
                end
            end
        end
    end

    function automatic int gap_len();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] rand_sample();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 16'h0000;
        if (roll == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_width();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return 16'd0;
        if (roll < 3)
            return 16'($urandom_range(9, PREFILL_WIDTH));
        return 16'($urandom_range(1, 8));
    endfunction

    function automatic logic [15:0] rand_height();
        if ($urandom_range(0, 19) == 0)
            return 16'd0;
        return 16'($urandom_range(1, 5));
    endfunction

    // Send one word after a random gap; entered and left at a falling edge
    task automatic send_word(input logic func, input logic [15:0] smp);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = func;
        s_axis_tdata  = smp;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    // Write a register once the block has gone quiet
    task automatic write_reg(input bbd_pkg::t_cfg_reg idx, input logic [15:0] val);
        s_axis_tvalid = 1'b0;
        while (chk_pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == bbd_pkg::CFG_WIDTH)
            cur_w = val[bbd_pkg::WIDTH_W-1:0];
        if (idx == bbd_pkg::CFG_HEIGHT)
            cur_h = val;
    endtask

    // Send frame content, mostly samples with a few early flushes
    task automatic send_content(input int count, input int flush_pct);
        repeat (count)
            send_word(($urandom_range(0, 99) < flush_pct) ? bbd_pkg::FUNC_FLUSH
                                                          : bbd_pkg::FUNC_SAMPLE,
                      rand_sample());
    endtask

    // Drain until the frame closes, mostly flushes with a few late samples
    task automatic drain_frame(input int sample_pct);
        while (!chk_at_frame_start)
            send_word(($urandom_range(0, 99) < sample_pct) ? bbd_pkg::FUNC_SAMPLE
                                                           : bbd_pkg::FUNC_FLUSH,
                      rand_sample());
    endtask

    initial begin
        int base, w_eff, h_eff, split;
        bbd_pkg::t_cfg_reg pick;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = bbd_pkg::FUNC_SAMPLE;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = bbd_pkg::CFG_PATTERN;
        i_cfg_wdata   = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Start at reset settings, narrow the line inside the frame; the
        // drain writes both line stores over every column used later
        send_content(5, 0);
        write_reg(bbd_pkg::CFG_WIDTH, 16'(PREFILL_WIDTH));
        send_content(PREFILL_WIDTH - 5, 2);
        drain_frame(5);

        // Small frame: sample extremes, an early flush, late samples in the drain
        write_reg(bbd_pkg::CFG_PATTERN, 16'd0);
        write_reg(bbd_pkg::CFG_ENABLE, 16'd1);
        write_reg(bbd_pkg::CFG_WIDTH, 16'd3);
        write_reg(bbd_pkg::CFG_HEIGHT, 16'd3);
        send_word(bbd_pkg::FUNC_SAMPLE, 16'hFFFF);
        send_word(bbd_pkg::FUNC_SAMPLE, 16'h0000);
        send_word(bbd_pkg::FUNC_SAMPLE, 16'hFFFF);
        send_word(bbd_pkg::FUNC_FLUSH,  16'h7E81);
        send_word(bbd_pkg::FUNC_SAMPLE, 16'hFFFF);
        send_word(bbd_pkg::FUNC_SAMPLE, 16'h0000);
        send_word(bbd_pkg::FUNC_SAMPLE, 16'h0001);
        send_word(bbd_pkg::FUNC_SAMPLE, 16'hFFFE);
        send_word(bbd_pkg::FUNC_SAMPLE, 16'h8000);
        drain_frame(50);

        // Zero geometry acts as a single pixel with no neighbors
        write_reg(bbd_pkg::CFG_PATTERN, 16'd3);
        write_reg(bbd_pkg::CFG_WIDTH, 16'd0);
        write_reg(bbd_pkg::CFG_HEIGHT, 16'd0);
        send_word(bbd_pkg::FUNC_SAMPLE, 16'hA5A5);
        drain_frame(0);

        // Bypass: the sample goes to all three channels
        write_reg(bbd_pkg::CFG_ENABLE, 16'd0);
        write_reg(bbd_pkg::CFG_PATTERN, 16'd1);
        write_reg(bbd_pkg::CFG_WIDTH, 16'd2);
        write_reg(bbd_pkg::CFG_HEIGHT, 16'd2);
        send_word(bbd_pkg::FUNC_SAMPLE, 16'hFFFF);
        send_word(bbd_pkg::FUNC_SAMPLE, 16'h0000);
        send_word(bbd_pkg::FUNC_SAMPLE, 16'h5555);
        send_word(bbd_pkg::FUNC_SAMPLE, 16'hAAAA);
        drain_frame(0);

        // Tallest height, then cut it below the current row inside the frame
        write_reg(bbd_pkg::CFG_ENABLE, 16'd1);
        write_reg(bbd_pkg::CFG_PATTERN, 16'd2);
        write_reg(bbd_pkg::CFG_WIDTH, 16'd3);
        write_reg(bbd_pkg::CFG_HEIGHT, 16'hFFFF);
        send_content(10, 0);
        write_reg(bbd_pkg::CFG_HEIGHT, 16'd2);
        drain_frame(0);

        // Random frames over all layouts, with geometry changes inside frames
        base = words_sent;
        while (words_sent - base < RANDOM_WORDS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1))
                write_reg(bbd_pkg::CFG_PATTERN, 16'($urandom_range(0, 3)));
            if ($urandom_range(0, 2) == 0)
                write_reg(bbd_pkg::CFG_ENABLE, ($urandom_range(0, 4) == 0) ? 16'd0 : 16'd1);
            if ($urandom_range(0, 3))
                write_reg(bbd_pkg::CFG_WIDTH, rand_width());
            if ($urandom_range(0, 3))
                write_reg(bbd_pkg::CFG_HEIGHT, rand_height());
            repeat ($urandom_range(1, 3)) begin
                w_eff = (cur_w == 0) ? 1 : ((cur_w > FULL_WIDTH) ? FULL_WIDTH : cur_w);
                h_eff = (cur_h == 0) ? 1 : cur_h;
                if ($urandom_range(0, 5) == 0) begin
                    split = $urandom_range(0, w_eff * h_eff);
                    send_content(split, 5);
                    pick = bbd_pkg::t_cfg_reg'($urandom_range(0, 3));
                    case (pick)
                        bbd_pkg::CFG_PATTERN:
                            write_reg(bbd_pkg::CFG_PATTERN, 16'($urandom_range(0, 3)));
                        bbd_pkg::CFG_ENABLE:
                            write_reg(bbd_pkg::CFG_ENABLE, 16'($urandom_range(0, 1)));
                        bbd_pkg::CFG_WIDTH:
                            write_reg(bbd_pkg::CFG_WIDTH, rand_width());
                        default:
                            write_reg(bbd_pkg::CFG_HEIGHT, rand_height());
                    endcase
                    send_content(w_eff * h_eff - split, 5);
                end else begin
                    send_content(w_eff * h_eff, 5);
                end
                drain_frame(10);
            end
        end

        // Oversized width acts as the full line; cut it back inside the frame
        no_idle = 1'b0;
        write_reg(bbd_pkg::CFG_PATTERN, 16'($urandom_range(0, 3)));
        write_reg(bbd_pkg::CFG_ENABLE, 16'd1);
        write_reg(bbd_pkg::CFG_WIDTH, 16'h1FFF);
        write_reg(bbd_pkg::CFG_HEIGHT, 16'd0);
        send_content(12, 2);
        write_reg(bbd_pkg::CFG_WIDTH, 16'd6);
        drain_frame(5);

        // Let the last pixels leave, then give the verdict
        s_axis_tvalid = 1'b0;
        while (chk_pending != 0)
            @(negedge i_clk);
        repeat (END_CYCLES) @(negedge i_clk);
        if (chk_fail_count == 0 && chk_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
